@@ rtl/smf_pkg.sv @@
package smf_pkg;

    // Operation codes carried on func
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Verdict codes of a result transaction
    localparam logic [2:0] VERDICT_HELD      = 3'd0;
    localparam logic [2:0] VERDICT_KEPT      = 3'd1;
    localparam logic [2:0] VERDICT_DOMINATED = 3'd2;
    localparam logic [2:0] VERDICT_FULL      = 3'd3;
    localparam logic [2:0] VERDICT_READ      = 3'd4;
    localparam logic [2:0] VERDICT_CLEARED   = 3'd5;

    // Reset value of the entry limit register
    localparam logic [10:0] LIMIT_RESET = 11'd1024;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       accept;        // input transaction taken this cycle
        logic       push;          // shift the incoming word into the pending mask
        logic       pad;           // shift a zero word into the pending mask
        logic       scan_start;    // reset scan counters
        logic       scan;          // walk the retained store
        logic       append;        // write the pending mask into the store
        logic       clear;         // empty the store
        logic       read_capture;  // latch read data for a read transaction
        logic       set_ovf;       // set the sticky overflow flag
        logic       out_load;      // load the output register
        logic [2:0] verdict;       // verdict for out_load
    } smf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pad_done;     // pending mask holds all words
        logic hit;          // current entry covers the candidate
        logic scan_done;    // all entries compared, none covers
        logic full;         // store at its effective limit
        logic append_last;  // last word of the append
        logic out_free;     // output register can take a result
    } smf_sts_t;

endpackage

@@ rtl/smf_ctrl.sv @@
module smf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         func,
    input  logic               end_of_mask,
    input  smf_pkg::smf_sts_t  sts,
    output smf_pkg::smf_cmd_t  cmd,
    output logic               in_stall,
    output logic               cfg_ready
);
    import smf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PAD    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] verdict_reg, verdict_next;

    // Input is taken only while idle
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        verdict_next = verdict_reg;
        cmd          = '0;
        cmd.verdict  = verdict_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (func)
                        FUNC_PUSH:
                        begin
                            cmd.push = 1'b1;
                            if (end_of_mask)
                            begin
                                state_next = S_PAD;
                            end
                            else
                            begin
                                verdict_next = VERDICT_HELD;
                                state_next   = S_DONE;
                            end
                        end
                        FUNC_READ:
                        begin
                            state_next = S_READ;
                        end
                        FUNC_CLEAR:
                        begin
                            cmd.clear    = 1'b1;
                            verdict_next = VERDICT_CLEARED;
                            state_next   = S_DONE;
                        end
                        default:
                        begin
                            verdict_next = VERDICT_HELD;
                            state_next   = S_DONE;
                        end
                    endcase
                end
            end
            S_PAD:
            begin
                if (sts.pad_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    cmd.pad = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    verdict_next = VERDICT_DOMINATED;
                    state_next   = S_DONE;
                end
                else if (sts.scan_done)
                begin
                    if (sts.full)
                    begin
                        cmd.set_ovf  = 1'b1;
                        verdict_next = VERDICT_FULL;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                if (sts.append_last)
                begin
                    verdict_next = VERDICT_KEPT;
                    state_next   = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.read_capture = 1'b1;
                verdict_next     = VERDICT_READ;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            verdict_reg <= VERDICT_HELD;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule

@@ rtl/smf_datapath.sv @@
module smf_datapath #(
    parameter int ENTRIES    = 1024,
    parameter int MASK_WORDS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  smf_pkg::smf_cmd_t  cmd,
    output smf_pkg::smf_sts_t  sts,
    input  logic [63:0]        mask_word,
    input  logic [9:0]         entry_index,
    input  logic [1:0]         word_index,
    input  logic               cfg_we,
    input  logic [10:0]        entry_limit,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [2:0]         verdict,
    output logic [63:0]        read_word,
    output logic [10:0]        retained_count,
    output logic               overflow
);
    import smf_pkg::*;

    localparam int DEPTH  = ENTRIES * MASK_WORDS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AC_W   = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int WW     = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
    localparam int PC_W   = $clog2(MASK_WORDS + 1);

    logic [63:0]       mem [DEPTH];
    logic [63:0]       rd_q_reg;
    logic [63:0]       pend_reg [MASK_WORDS];
    logic [PC_W-1:0]   pcount_reg;
    logic [CNT_W-1:0]  kept_reg;
    logic [CNT_W-1:0]  ent_reg;
    logic [WW-1:0]     wrd_reg;
    logic [AC_W-1:0]   addr_reg;
    logic              ovf_reg;
    logic [10:0]       limit_reg;
    logic              cmp_vld_reg;
    logic              cmp_last_reg;
    logic              miss_reg;
    logic              rd_ok_reg;
    logic [63:0]       res_word_reg;
    logic              out_valid_reg;
    logic [2:0]        verdict_reg;
    logic [63:0]       read_word_reg;
    logic [10:0]       count_out_reg;
    logic              ovf_out_reg;

    logic              word_last;
    logic              entries_left;
    logic              issue;
    logic              word_miss;
    logic              cmp_en;
    logic              room;
    logic              pend_shift;
    logic [63:0]       pend_top;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_ok;

    // Scan and append sequencing
    assign word_last    = (wrd_reg == WW'(MASK_WORDS - 1));
    assign entries_left = (ent_reg < kept_reg);
    assign issue        = cmd.scan && entries_left;
    assign cmp_en       = cmd.scan && cmp_vld_reg;
    // Candidate bit not present in the stored word
    assign word_miss    = |(pend_reg[0] & ~rd_q_reg);

    // Pending mask shift line: push, zero pad, or rotate during compare/append
    assign room       = (pcount_reg < PC_W'(MASK_WORDS));
    assign pend_shift = (cmd.push && room) || cmd.pad || cmp_en || cmd.append;
    assign pend_top   = cmd.push ? mask_word : (cmd.pad ? 64'd0 : pend_reg[0]);

    // Read address: a read transaction's entry and word on accept, else the scan walk
    assign in_addr = ADDR_W'(32'(entry_index) * MASK_WORDS + 32'(word_index));
    assign rd_addr = cmd.accept ? in_addr : addr_reg[ADDR_W-1:0];
    assign rd_ok   = (32'(entry_index) < 32'(kept_reg)) && (32'(word_index) < MASK_WORDS);

    // Status back to the controller
    always_comb
    begin
        sts.pad_done    = (pcount_reg == PC_W'(MASK_WORDS));
        sts.hit         = cmp_vld_reg && cmp_last_reg && !(miss_reg || word_miss);
        sts.scan_done   = !entries_left && !cmp_vld_reg;
        sts.full        = (32'(kept_reg) >= 32'(limit_reg)) || (32'(kept_reg) >= ENTRIES);
        sts.append_last = word_last;
        sts.out_free    = !out_valid_reg || !out_stall;
    end

    // Retained store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem[addr_reg[ADDR_W-1:0]] <= pend_reg[0];
        end
        rd_q_reg <= mem[rd_addr];
    end

    // Pending mask
    always_ff @(posedge clk)
    begin
        if (pend_shift)
        begin
            for (int i = 0; i < MASK_WORDS - 1; i++)
            begin
                pend_reg[i] <= pend_reg[i + 1];
            end
            pend_reg[MASK_WORDS - 1] <= pend_top;
        end
    end

    // Counters, flags and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg   <= '0;
            kept_reg     <= '0;
            ovf_reg      <= 1'b0;
            limit_reg    <= LIMIT_RESET;
            ent_reg      <= '0;
            wrd_reg      <= '0;
            addr_reg     <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_last_reg <= 1'b0;
            miss_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= entry_limit;
            end

            if (cmd.clear || cmd.scan_start)
            begin
                pcount_reg <= '0;
            end
            else if ((cmd.push && room) || cmd.pad)
            begin
                pcount_reg <= pcount_reg + 1'b1;
            end

            if (cmd.clear)
            begin
                kept_reg <= '0;
            end
            else if (cmd.append && word_last)
            begin
                kept_reg <= kept_reg + 1'b1;
            end

            if (cmd.clear)
            begin
                ovf_reg <= 1'b0;
            end
            else if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end

            // Address walk shared by scan and append
            if (cmd.scan_start)
            begin
                ent_reg  <= '0;
                wrd_reg  <= '0;
                addr_reg <= '0;
            end
            else if (issue || cmd.append)
            begin
                addr_reg <= addr_reg + 1'b1;
                wrd_reg  <= word_last ? '0 : wrd_reg + 1'b1;
                if (issue && word_last)
                begin
                    ent_reg <= ent_reg + 1'b1;
                end
            end

            // Compare flags are registered alongside the store read, so they line up with its data
            cmp_vld_reg  <= issue && !cmd.scan_start;
            cmp_last_reg <= issue && word_last;

            if (cmd.scan_start)
            begin
                miss_reg <= 1'b0;
            end
            else if (cmp_en)
            begin
                miss_reg <= cmp_last_reg ? 1'b0 : (miss_reg || word_miss);
            end
        end
    end

    // Read data staging
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_ok_reg    <= rd_ok;
            res_word_reg <= 64'd0;
        end
        else if (cmd.read_capture)
        begin
            res_word_reg <= rd_ok_reg ? rd_q_reg : 64'd0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            verdict_reg   <= cmd.verdict;
            read_word_reg <= res_word_reg;
            count_out_reg <= 11'(32'(kept_reg));
            ovf_out_reg   <= ovf_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign read_word      = read_word_reg;
    assign retained_count = count_out_reg;
    assign overflow       = ovf_out_reg;

endmodule

@@ rtl/subset_maximal_set_filter_unit.sv @@
// Subset-maximal set filter.
// Input channel (in_valid/in_stall): one transaction per func. func push
// delivers one 64-bit mask word, lowest first; end_of_mask completes the
// candidate. func read returns one retained word, func clear empties the
// store. Complete masks must arrive sorted by nonincreasing popcount.
// Output channel (out_valid/out_stall): exactly one result transaction per
// input transaction, in order, carrying verdict, read_word, retained_count
// and the sticky overflow flag.
// Config channel (cfg_valid/cfg_ready): writes entry_limit while idle.
// A complete mask is padded with zero words up to MASK_WORDS, then scanned
// against every retained entry over the single store read port, ending early
// on a hit, then appended word by word unless dominated or the store is full,
// and then sent to the output. One transaction is in work at a time.
// Reset empties the store, clears overflow and sets entry_limit to 1024;
// no clearing pass is needed. A stalled result is held in the output
// register; the next input transaction is taken while it waits, and its
// result waits in turn until the register frees.
module subset_maximal_set_filter_unit #(
    parameter int ENTRIES    = 1024,
    parameter int MASK_WORDS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [63:0] mask_word,
    input  logic        end_of_mask,
    input  logic [9:0]  entry_index,
    input  logic [1:0]  word_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  verdict,
    output logic [63:0] read_word,
    output logic [10:0] retained_count,
    output logic        overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] entry_limit
);
    import smf_pkg::*;

    smf_cmd_t cmd;
    smf_sts_t sts;
    logic     cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    smf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .func        (func),
        .end_of_mask (end_of_mask),
        .sts         (sts),
        .cmd         (cmd),
        .in_stall    (in_stall),
        .cfg_ready   (cfg_ready)
    );

    smf_datapath #(
        .ENTRIES    (ENTRIES),
        .MASK_WORDS (MASK_WORDS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .mask_word      (mask_word),
        .entry_index    (entry_index),
        .word_index     (word_index),
        .cfg_we         (cfg_we),
        .entry_limit    (entry_limit),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .verdict        (verdict),
        .read_word      (read_word),
        .retained_count (retained_count),
        .overflow       (overflow)
    );

endmodule

@@ rtl/smf_checker.sv @@
module smf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  verdict,
    input logic [63:0] read_word,
    input logic [10:0] retained_count,
    input logic        overflow
);
    import smf_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(read_word)
            && $stable(retained_count) && $stable(overflow))
        else $error("stalled result changed");

    // A clear leaves an empty store and no overflow
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == VERDICT_CLEARED |-> retained_count == 11'd0 && !overflow)
        else $error("clear left state behind");

    // A drop on a full store raises overflow
    a_full_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == VERDICT_FULL |-> overflow)
        else $error("full drop without overflow");

    // Only read transactions carry data
    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict != VERDICT_READ |-> read_word == 64'd0)
        else $error("read_word nonzero outside a read");

endmodule

bind subset_maximal_set_filter_unit smf_checker u_smf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .verdict        (verdict),
    .read_word      (read_word),
    .retained_count (retained_count),
    .overflow       (overflow)
);

@@ tb/tb_subset_maximal_set_filter_unit.sv @@
module tb_subset_maximal_set_filter_unit;
    import smf_pkg::*;

    localparam int ENTRIES      = 1024;
    localparam int MASK_WORDS   = 4;
    localparam int RANDOM_ITEMS = 110;
    localparam int HOLD_LEN     = 300;
    localparam int SETTLE       = 4;
    localparam int TAIL_CYCLES  = 20;
    localparam int LIMIT_CYCLES = 1000000;

    // func 3 is not an operation; the block answers it as a held word
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN, OP_HOLD} op_kind_t;

    typedef struct {
        op_kind_t    kind;
        logic [1:0]  func;
        logic [63:0] word;
        logic        eom;
        logic [9:0]  eidx;
        logic [1:0]  widx;
        logic [10:0] limit;
    } op_t;

    typedef struct {
        logic [2:0]  verdict;
        logic [63:0] read_word;
        logic [10:0] retained_count;
        logic        overflow;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = FUNC_PUSH;
    logic [63:0] mask_word = '0;
    logic        end_of_mask = 1'b0;
    logic [9:0]  entry_index = '0;
    logic [1:0]  word_index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  verdict;
    logic [63:0] read_word;
    logic [10:0] retained_count;
    logic        overflow;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] entry_limit = LIMIT_RESET;

    subset_maximal_set_filter_unit #(
        .ENTRIES    (ENTRIES),
        .MASK_WORDS (MASK_WORDS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .mask_word      (mask_word),
        .end_of_mask    (end_of_mask),
        .entry_index    (entry_index),
        .word_index     (word_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verdict        (verdict),
        .read_word      (read_word),
        .retained_count (retained_count),
        .overflow       (overflow),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .entry_limit    (entry_limit)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Filter state as the block should hold it
    logic [63:0] kept_masks [ENTRIES][MASK_WORDS];
    logic [63:0] cand_mask [MASK_WORDS];
    int          cand_words = 0;
    int          kept_total = 0;
    logic        overflow_sticky = 1'b0;
    int          limit_shadow = LIMIT_RESET;

    op_t         stimulus_ops [$];
    result_t     due_results [$];
    int          errors = 0;
    int          counted_items = 0;
    logic [7:0]  hold_token = '0;

    // Generator-side bookkeeping for popcount ordering and subset picks
    int           pop_ceiling = 256;
    logic [255:0] mask_history [$];

    // Work out the result of one accepted transaction and advance the state
    function automatic result_t judge_item(op_t t);
        result_t r;
        int      w;
        int      e;
        int      cap;
        logic    hit;
        logic    found;
        r.verdict   = VERDICT_HELD;
        r.read_word = '0;
        case (t.func)
            FUNC_PUSH:
            begin
                // words past MASK_WORDS are dropped
                if (cand_words < MASK_WORDS)
                begin
                    cand_mask[cand_words] = t.word;
                    cand_words++;
                end
                if (t.eom)
                begin
                    // missing words of a short mask count as zero
                    for (w = cand_words; w < MASK_WORDS; w++)
                        cand_mask[w] = '0;
                    cand_words = 0;
                    found = 1'b0;
                    for (e = 0; e < kept_total && !found; e++)
                    begin
                        hit = 1'b1;
                        for (w = 0; w < MASK_WORDS; w++)
                            if ((cand_mask[w] & ~kept_masks[e][w]) != '0)
                                hit = 1'b0;
                        found = hit;
                    end
                    cap = (limit_shadow < ENTRIES) ? limit_shadow : ENTRIES;
                    if (found)
                        r.verdict = VERDICT_DOMINATED;
                    else if (kept_total >= cap)
                    begin
                        overflow_sticky = 1'b1;
                        r.verdict = VERDICT_FULL;
                    end
                    else
                    begin
                        for (w = 0; w < MASK_WORDS; w++)
                            kept_masks[kept_total][w] = cand_mask[w];
                        kept_total++;
                        r.verdict = VERDICT_KEPT;
                    end
                end
            end
            FUNC_READ:
            begin
                r.verdict = VERDICT_READ;
                if (t.eidx < kept_total && t.widx < MASK_WORDS)
                    r.read_word = kept_masks[t.eidx][t.widx];
            end
            FUNC_CLEAR:
            begin
                r.verdict = VERDICT_CLEARED;
                kept_total = 0;
                overflow_sticky = 1'b0;
                cand_words = 0;
            end
            default: ;
        endcase
        r.retained_count = 11'(kept_total);
        r.overflow = overflow_sticky;
        return r;
    endfunction

    // Idle stretch: mostly short, a few long
    function automatic int idle_len();
        int p;
        p = $urandom_range(99);
        if (p < 70)
            return $urandom_range(3, 1);
        if (p < 95)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Queue one input transaction; fields the func ignores get random values
    function automatic void add_item(logic [1:0] f, logic [63:0] word, logic eom,
                                     logic [9:0] ei, logic [1:0] wi);
        op_t t;
        t.kind  = OP_ITEM;
        t.func  = f;
        t.word  = (f == FUNC_PUSH) ? word : {$urandom, $urandom};
        t.eom   = (f == FUNC_PUSH) ? eom : 1'($urandom);
        t.eidx  = (f == FUNC_READ) ? ei : 10'($urandom);
        t.widx  = (f == FUNC_READ) ? wi : 2'($urandom);
        t.limit = '0;
        stimulus_ops.insert(stimulus_ops.size(), t);
        if (f != FUNC_UNUSED)
            counted_items++;
    endfunction

    function automatic void add_op(op_kind_t k, logic [10:0] lim);
        op_t t;
        t.kind  = k;
        t.func  = FUNC_PUSH;
        t.word  = '0;
        t.eom   = 1'b0;
        t.eidx  = '0;
        t.widx  = '0;
        t.limit = lim;
        stimulus_ops.insert(stimulus_ops.size(), t);
    endfunction

    function automatic void add_read();
        logic [9:0] ei;
        if ($urandom_range(99) < 75)
            ei = 10'($urandom_range(mask_history.size() < 1023 ? mask_history.size() : 1023));
        else
            ei = 10'($urandom_range(1023));
        add_item(FUNC_READ, '0, 1'b0, ei, 2'($urandom_range(3)));
    endfunction

    function automatic void gen_clear();
        add_item(FUNC_CLEAR, '0, 1'b0, '0, '0);
        pop_ceiling = 256;
        mask_history.delete();
    endfunction

    // Queue a whole mask, trimmed so popcounts never rise within a store;
    // read_at puts a read before that word, -1 for none
    function automatic void push_mask(logic [255:0] m, int nwords, int read_at);
        logic [255:0] eff;
        int           pop;
        int           w;
        int           b;
        eff = m;
        for (w = nwords; w < MASK_WORDS; w++)
            eff[w*64 +: 64] = '0;
        pop = $countones(eff);
        while (pop > pop_ceiling)
        begin
            b = $urandom_range(255);
            if (eff[b])
            begin
                eff[b] = 1'b0;
                pop--;
            end
        end
        pop_ceiling = pop;
        mask_history.insert(mask_history.size(), eff);
        for (w = 0; w < nwords; w++)
        begin
            if (w == read_at)
                add_read();
            add_item(FUNC_PUSH, (w < MASK_WORDS) ? eff[w*64 +: 64] : {$urandom, $urandom},
                     w == nwords - 1, '0, '0);
        end
    endfunction

    // Driver: offers queued transactions, config writes and pauses
    always @(posedge clk or negedge rst_n)
    begin : drive_inputs
        op_t  cur;
        int   gap_left;
        int   settle_cnt;
        logic calm;
        logic nv;
        logic ncv;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            cfg_valid  <= 1'b0;
            gap_left   = 0;
            settle_cnt = 0;
            calm       = 1'b0;
        end
        else
        begin
            nv  = in_valid;
            ncv = cfg_valid;
            if ($urandom_range(255) == 0)
                calm = !calm;
            if (in_valid && !in_stall)
            begin
                due_results.insert(due_results.size(), judge_item(cur));
                nv = 1'b0;
                gap_left = (calm || $urandom_range(1) == 0) ? 0 : idle_len();
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_shadow = cur.limit;
                ncv = 1'b0;
            end
            if (!nv && !ncv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (stimulus_ops.size() != 0)
                begin
                    case (stimulus_ops[0].kind)
                        OP_ITEM:
                        begin
                            cur = stimulus_ops.pop_front();
                            func        <= cur.func;
                            mask_word   <= cur.word;
                            end_of_mask <= cur.eom;
                            entry_index <= cur.eidx;
                            word_index  <= cur.widx;
                            nv = 1'b1;
                        end
                        OP_HOLD:
                        begin
                            void'(stimulus_ops.pop_front());
                            hold_token <= hold_token + 8'd1;
                        end
                        default:
                        begin
                            // config writes and pauses wait for an idle block
                            if (due_results.size() != 0)
                                settle_cnt = 0;
                            else if (settle_cnt < SETTLE)
                                settle_cnt++;
                            else
                            begin
                                settle_cnt = 0;
                                cur = stimulus_ops.pop_front();
                                if (cur.kind == OP_CFG)
                                begin
                                    entry_limit <= cur.limit;
                                    ncv = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            in_valid  <= nv;
            cfg_valid <= ncv;
        end
    end

    // Monitor: stalls at random, checks each result transaction
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        result_t    want;
        int         stall_left;
        int         hold_left;
        logic [7:0] hold_seen;
        logic       calm;
        logic       ns;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_seen  = '0;
            calm       = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: verdict %0d, count %0d", verdict, retained_count);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (verdict !== want.verdict)
                    begin
                        $error("verdict: expected %0d, got %0d", want.verdict, verdict);
                        errors++;
                    end
                    if (read_word !== want.read_word)
                    begin
                        $error("read_word: expected %h, got %h", want.read_word, read_word);
                        errors++;
                    end
                    if (retained_count !== want.retained_count)
                    begin
                        $error("retained_count: expected %0d, got %0d",
                               want.retained_count, retained_count);
                        errors++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d", want.overflow, overflow);
                        errors++;
                    end
                end
            end
            if ($urandom_range(255) == 0)
                calm = !calm;
            // long hold-off on request, otherwise random stalls
            if (hold_left > 0)
            begin
                hold_left--;
                ns = 1'b1;
            end
            else if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_LEN - 1;
                ns = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                ns = 1'b1;
            end
            else if (!calm && $urandom_range(99) < 30)
            begin
                stall_left = idle_len() - 1;
                ns = 1'b1;
            end
            else
                ns = 1'b0;
            out_stall <= ns;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin : watchdog
        int cycles;
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [255:0] m;
        int           sel;
        int           nwords;
        int           read_at;
        int           len;
        int           base;
        int           k;

        // Directed: empty reads, unused func, extremes of the mask words
        add_op(OP_CFG, LIMIT_RESET);
        add_read();
        add_item(FUNC_UNUSED, '0, 1'b0, '0, '0);
        push_mask({256{1'b1}}, 4, -1);
        push_mask('0, 1, -1);
        add_item(FUNC_READ, '0, 1'b0, 10'd0, 2'd3);
        add_item(FUNC_READ, '0, 1'b0, 10'd1023, 2'd2);
        gen_clear();
        // overlong mask, then a short one with a read in the middle
        push_mask({4{64'hAAAA_AAAA_AAAA_AAAA}}, 6, -1);
        push_mask({192'b0, 64'hFFFF_FFFF_0000_0000}, 3, 1);
        // clear drops a partly pushed mask
        add_item(FUNC_PUSH, {64{1'b1}}, 1'b0, '0, '0);
        gen_clear();
        push_mask({255'b0, 1'b1}, 1, -1);
        add_item(FUNC_READ, '0, 1'b0, 10'd0, 2'd0);
        // limit of one: second survivor overflows, clear drops the flag
        add_op(OP_CFG, 11'd1);
        gen_clear();
        push_mask({248'b0, 8'hF0}, 1, -1);
        push_mask({248'b0, 8'h0F}, 1, -1);
        gen_clear();
        // zero limit and a limit above the store
        add_op(OP_CFG, 11'd0);
        push_mask({255'b0, 1'b1}, 1, -1);
        add_op(OP_CFG, 11'd2047);
        gen_clear();
        push_mask({254'b0, 2'b11}, 1, -1);
        base = counted_items;

        // Long receiver hold-off while cheap transactions keep coming
        gen_clear();
        add_op(OP_HOLD, '0);
        repeat (6)
        begin
            add_read();
            push_mask({192'b0, $urandom, $urandom}, 1, -1);
        end

        // Random phases, each with its own limit
        while (counted_items < base + RANDOM_ITEMS)
        begin
            case ($urandom_range(5))
                0: add_op(OP_CFG, LIMIT_RESET);
                1: add_op(OP_CFG, 11'd2047);
                2: add_op(OP_CFG, 11'd0);
                3: add_op(OP_CFG, 11'd1);
                default: add_op(OP_CFG, 11'($urandom_range(12, 2)));
            endcase
            gen_clear();
            len = $urandom_range(30, 12);
            while (len > 0 && counted_items < base + RANDOM_ITEMS)
            begin
                len--;
                sel = $urandom_range(99);
                if (sel < 72)
                begin
                    for (k = 0; k < MASK_WORDS; k++)
                        m[k*64 +: 64] = {$urandom, $urandom};
                    k = $urandom_range(99);
                    if (k >= 45 && k < 65)
                        m = m & {$urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom};
                    else if (k >= 65 && k < 90 && mask_history.size() != 0)
                        m = m & mask_history[$urandom_range(mask_history.size() - 1)];
                    else if (k >= 90 && mask_history.size() != 0)
                        m = mask_history[$urandom_range(mask_history.size() - 1)];
                    k = $urandom_range(99);
                    if (k < 75)
                        nwords = MASK_WORDS;
                    else if (k < 90)
                        nwords = $urandom_range(MASK_WORDS - 1, 1);
                    else
                        nwords = $urandom_range(MASK_WORDS + 2, MASK_WORDS + 1);
                    read_at = (nwords > 1 && $urandom_range(99) < 15)
                              ? $urandom_range(nwords - 1, 1) : -1;
                    push_mask(m, nwords, read_at);
                end
                else if (sel < 84)
                    add_read();
                else if (sel < 88)
                    add_item(FUNC_UNUSED, '0, 1'b0, '0, '0);
                else if (sel < 92)
                begin
                    // broken sequence: words with no end, then a clear
                    repeat ($urandom_range(3, 1))
                        add_item(FUNC_PUSH, {$urandom, $urandom}, 1'b0, '0, '0);
                    gen_clear();
                end
                else if (sel < 96)
                    add_op(OP_DRAIN, '0);
                else
                    gen_clear();
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every transaction to be offered and answered
        while (stimulus_ops.size() != 0 || in_valid || cfg_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/smf_pkg.sv
rtl/smf_ctrl.sv
rtl/smf_datapath.sv
rtl/subset_maximal_set_filter_unit.sv
rtl/smf_checker.sv
tb/tb_subset_maximal_set_filter_unit.sv
